// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication under clock and active-low reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under clock and active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/lrip_pkg.sv =====
// ----------------------------------------------------------------------------
// lrip_pkg
// Constants and types for the lidar range image projection block.
// ----------------------------------------------------------------------------
package lrip_pkg;

  localparam int unsigned CordicSteps = 24;
  localparam int unsigned AngW        = 29;
  localparam logic signed [AngW-1:0] AngPi     = 29'sd52707179;
  localparam logic signed [AngW-1:0] AngHalfPi = 29'sd26353589;
  localparam logic [27:0]            AngTwoPi  = 28'd105414357;

  localparam logic [2:0] StStored  = 3'd0;
  localparam logic [2:0] StRingOut = 3'd1;
  localparam logic [2:0] StSkipped = 3'd2;
  localparam logic [2:0] StClose   = 3'd3;
  localparam logic [2:0] StTaken   = 3'd4;

  localparam logic CfgRate   = 1'b0;
  localparam logic CfgMinRng = 1'b1;

  function automatic logic [23:0] atan_rom(input logic [4:0] i);
    logic [23:0] r;
    begin
      unique case (i)
        5'd0:  r = 24'd13176795;
        5'd1:  r = 24'd7778716;
        5'd2:  r = 24'd4110060;
        5'd3:  r = 24'd2086331;
        5'd4:  r = 24'd1047214;
        5'd5:  r = 24'd524117;
        5'd6:  r = 24'd262123;
        5'd7:  r = 24'd131069;
        default: r = 24'd1 << (5'd24 - i);
      endcase
      return r;
    end
  endfunction

endpackage

// ===== rtl/lrip_cordic.sv =====
// ----------------------------------------------------------------------------
// lrip_cordic
// Vectoring CORDIC, one rotation per cycle, giving atan2(x, y) in 2^-24 rad.
// ----------------------------------------------------------------------------
module lrip_cordic (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [16:0]                    x_i,
  input  logic signed [16:0]                    y_i,
  output logic                                  done_o,
  output logic signed [lrip_pkg::AngW-1:0]      ang_o
);

  logic signed [36:0] p_q, p_d, q_q, q_d;
  logic signed [lrip_pkg::AngW-1:0] z_q, z_d;
  logic [4:0] i_q, i_d;
  logic busy_q, busy_d, done_q, done_d;
  logic signed [36:0] p0, q0, dp, dq;
  logic signed [lrip_pkg::AngW-1:0] a;

  always_comb begin
    p0 = 37'(y_i) <<< 16;
    q0 = 37'(x_i) <<< 16;
    p_d = p_q; q_d = q_q; z_d = z_q; i_d = i_q; busy_d = busy_q; done_d = 1'b0;
    dp = q_q >>> i_q;
    dq = p_q >>> i_q;
    a = lrip_pkg::AngW'(lrip_pkg::atan_rom(i_q));
    if (start_i) begin
      if (x_i == '0 && y_i == '0) begin
        z_d = '0; busy_d = 1'b0; done_d = 1'b1;
      end else begin
        busy_d = 1'b1; i_d = '0;
        if (p0 < 0) begin
          z_d = (q0 >= 0) ? lrip_pkg::AngPi : -lrip_pkg::AngPi;
          p_d = -p0; q_d = -q0;
        end else begin
          z_d = '0; p_d = p0; q_d = q0;
        end
      end
    end else if (busy_q) begin
      if (q_q >= 0) begin
        p_d = p_q + dp; q_d = q_q - dq; z_d = z_q + a;
      end else begin
        p_d = p_q - dp; q_d = q_q + dq; z_d = z_q - a;
      end
      i_d = i_q + 5'd1;
      if (i_q == 5'(lrip_pkg::CordicSteps - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; i_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; q_q <= q_d; z_q <= z_d;
  end

  assign done_o = done_q;
  assign ang_o  = z_q;

endmodule

// ===== rtl/lrip_isqrt.sv =====
// ----------------------------------------------------------------------------
// lrip_isqrt
// Sum of squares by shift-add, then digit-by-digit rounded square root.
// ----------------------------------------------------------------------------
module lrip_isqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] x_i,
  input  logic signed [16:0] y_i,
  input  logic signed [16:0] z_i,
  output logic               done_o,
  output logic [16:0]        root_o
);

  localparam logic [1:0] PhSq = 2'd1;
  localparam logic [1:0] PhRt = 2'd2;
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhRnd = 2'd3;

  logic [1:0] ph_q, ph_d;
  logic [1:0] ax_q, ax_d;
  logic [4:0] n_q, n_d;
  logic [16:0] m_q, m_d;
  logic [35:0] acc_q, acc_d, s_q, s_d;
  logic [35:0] r_q, r_d;
  logic done_q, done_d;
  logic [16:0] mag;
  logic [35:0] bit_v, trial;

  function automatic logic [16:0] absv(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

  always_comb begin
    ph_d = ph_q; ax_d = ax_q; n_d = n_q; m_d = m_q; acc_d = acc_q;
    s_d = s_q; r_d = r_q; done_d = 1'b0;
    mag = '0;
    unique case (ax_q)
      2'd0: mag = absv(x_i);
      2'd1: mag = absv(y_i);
      default: mag = absv(z_i);
    endcase
    bit_v = 36'd1 << {n_q, 1'b0};
    trial = r_q + bit_v;
    unique case (ph_q)
      PhIdle: begin
        if (start_i) begin
          ph_d = PhSq; ax_d = 2'd0; n_d = '0; acc_d = '0; m_d = absv(x_i);
        end
      end
      PhSq: begin
        if (m_q[0]) acc_d = acc_q + (36'(mag) << n_q);
        m_d = m_q >> 1;
        n_d = n_q + 5'd1;
        if (n_q == 5'd16) begin
          n_d = '0;
          if (ax_q == 2'd2) begin
            ph_d = PhRt; s_d = acc_d; r_d = '0; n_d = 5'd17;
          end else begin
            ax_d = ax_q + 2'd1;
            m_d = (ax_q == 2'd0) ? absv(y_i) : absv(z_i);
          end
        end
      end
      PhRt: begin
        if (s_q >= trial) begin
          s_d = s_q - trial; r_d = (r_q >> 1) + bit_v;
        end else begin
          r_d = r_q >> 1;
        end
        n_d = n_q - 5'd1;
        if (n_q == 5'd0) ph_d = PhRnd;
      end
      default: begin
        if (s_q > r_q) r_d = r_q + 36'd1;
        ph_d = PhIdle; done_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhIdle; done_q <= 1'b0; ax_q <= '0; n_q <= '0;
    end else begin
      ph_q <= ph_d; done_q <= done_d; ax_q <= ax_d; n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d; acc_q <= acc_d; s_q <= s_d; r_q <= r_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[16:0];

endmodule

// ===== rtl/lidar_range_image_projection_top.sv =====
// Flow: after the input transaction the ring check subtracts the rate step by step; then
// the CORDIC and the squares/root run together, then a restoring divide, index, read and
// decide states lead to the result. A ring out of range goes straight to the result.
// One point at a time: the next one is taken the cycle after the result transaction.
// Reset: asynchronous active low; then a clearing pass over the RING_COUNT*COLUMN_COUNT
// cells, one cell per cycle, with input stalled. Frame start runs the same pass first.
// ----------------------------------------------------------------------------
// lidar_range_image_projection_top
// Projects lidar points into a range image with a one-bit occupancy map.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lidar_range_image_projection_top #(
  parameter int unsigned RING_COUNT   = 16,
  parameter int unsigned COLUMN_COUNT = 1800
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               frame_start_i,
  input  logic signed [16:0] pos_x_i,
  input  logic signed [16:0] pos_y_i,
  input  logic signed [16:0] pos_z_i,
  input  logic [15:0]        intensity_i,
  input  logic [15:0]        ring_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic [6:0]         row_o,
  output logic [11:0]        column_o,
  output logic [18:0]        cell_index_o,
  output logic [16:0]        range_o,
  output logic signed [16:0] out_x_o,
  output logic signed [16:0] out_y_o,
  output logic signed [16:0] out_z_o,
  output logic [15:0]        out_intensity_o
);

  localparam int unsigned CellTotal = RING_COUNT * COLUMN_COUNT;
  localparam int unsigned CellW = (CellTotal > 1) ? $clog2(CellTotal) : 1;
  localparam int unsigned ProdW = lrip_pkg::AngW + 14;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SClear = 4'd1;
  localparam logic [3:0] SCheck = 4'd2;
  localparam logic [3:0] SMod   = 4'd3;
  localparam logic [3:0] SStart = 4'd4;
  localparam logic [3:0] SWait  = 4'd5;
  localparam logic [3:0] SMul   = 4'd6;
  localparam logic [3:0] SDiv   = 4'd7;
  localparam logic [3:0] SIdx   = 4'd8;
  localparam logic [3:0] SRead  = 4'd9;
  localparam logic [3:0] SDec   = 4'd10;
  localparam logic [3:0] SOut   = 4'd11;

  logic [3:0] st_q, st_d;
  logic [7:0] rate_q;
  logic [15:0] minr_q;
  logic [CellW-1:0] clr_q, clr_d;
  logic fs_q;
  logic signed [16:0] x_q, y_q, z_q;
  logic [15:0] int_q, ring_q;
  logic [15:0] rem_q, rem_d;
  logic [2:0] status_q, status_d;
  logic [11:0] col_q, col_d;
  logic [18:0] idx_q, idx_d;
  logic [16:0] rng_q;
  logic cdone_q, rdone_q;
  logic signed [ProdW-1:0] prod_q;
  logic [ProdW-1:0] k_q, mag_q;
  logic [ProdW-1:0] num_q;
  logic [5:0] dn_q;
  logic taken_q;
  logic mem [CellTotal];
  logic [CellW-1:0] maddr;
  logic mwe, mwd;

  logic start_u;
  logic cdone, rdone;
  logic signed [lrip_pkg::AngW-1:0] ang;
  logic [16:0] root;
  logic [7:0] rate_eff;
  logic [ProdW:0] den;
  logic signed [13:0] colc;

  lrip_cordic u_cordic (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_u), .x_i(x_q), .y_i(y_q),
    .done_o(cdone), .ang_o(ang)
  );

  lrip_isqrt u_isqrt (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_u), .x_i(x_q), .y_i(y_q),
    .z_i(z_q), .done_o(rdone), .root_o(root)
  );

  assign start_u  = (st_q == SStart);
  assign rate_eff = (rate_q == '0) ? 8'd1 : rate_q;
  assign den      = (ProdW+1)'(2 * lrip_pkg::AngTwoPi);
  assign in_stall_o  = (st_q != SIdle);
  assign out_valid_o = (st_q == SOut);

  always_comb begin
    st_d = st_q; clr_d = clr_q; rem_d = rem_q; status_d = status_q;
    col_d = col_q; idx_d = idx_q;
    maddr = clr_q; mwe = 1'b0; mwd = 1'b0;
    colc = '0;
    unique case (st_q)
      SIdle: begin
        if (in_valid_i) begin
          rem_d = ring_i; col_d = '0; idx_d = '0;
          st_d = frame_start_i ? SClear : SCheck;
          clr_d = '0;
        end
      end
      SClear: begin
        mwe = 1'b1;
        clr_d = clr_q + CellW'(1);
        if (clr_q == CellW'(CellTotal - 1)) st_d = fs_q ? SCheck : SIdle;
      end
      SCheck: begin
        if (ring_q >= 16'(RING_COUNT)) begin
          status_d = lrip_pkg::StRingOut; st_d = SOut;
        end else begin
          st_d = SMod;
        end
      end
      SMod: begin
        if (rem_q >= 16'(rate_eff)) begin
          rem_d = rem_q - 16'(rate_eff);
        end else if (rem_q != '0) begin
          status_d = lrip_pkg::StSkipped; st_d = SOut;
        end else begin
          st_d = SStart;
        end
      end
      SStart: st_d = SWait;
      SWait: if (cdone_q && rdone_q) st_d = SMul;
      SMul: st_d = SDiv;
      SDiv: if (dn_q == '0) st_d = SIdx;
      SIdx: begin
        colc = 14'(COLUMN_COUNT / 2) - (prod_q < 0 ? -14'(k_q) : 14'(k_q));
        if (colc < 0) colc = colc + 14'(COLUMN_COUNT);
        else if (colc >= 14'(COLUMN_COUNT)) colc = colc - 14'(COLUMN_COUNT);
        col_d = 12'(colc);
        idx_d = 19'(colc) + 19'(ring_q) * 19'(COLUMN_COUNT);
        st_d = SRead;
      end
      SRead: begin
        maddr = CellW'(idx_q);
        st_d = SDec;
      end
      SDec: begin
        maddr = CellW'(idx_q);
        if (rng_q < 17'(minr_q)) status_d = lrip_pkg::StClose;
        else if (idx_q < 19'(CellTotal) && taken_q) status_d = lrip_pkg::StTaken;
        else begin
          status_d = lrip_pkg::StStored;
          mwe = (idx_q < 19'(CellTotal)); mwd = 1'b1;
        end
        st_d = SOut;
      end
      SOut: if (!out_stall_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClear; clr_q <= '0; fs_q <= 1'b0; rate_q <= 8'd1;
      minr_q <= 16'd256; cdone_q <= 1'b0; rdone_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d;
      if (st_q == SIdle && in_valid_i) fs_q <= frame_start_i;
      if (cfg_we_i) begin
        if (cfg_index_i == lrip_pkg::CfgRate) rate_q <= cfg_data_i[7:0];
        else if (cfg_index_i == lrip_pkg::CfgMinRng) minr_q <= cfg_data_i;
      end
      if (start_u) begin
        cdone_q <= 1'b0; rdone_q <= 1'b0;
      end else begin
        if (cdone) cdone_q <= 1'b1;
        if (rdone) rdone_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && in_valid_i) begin
      x_q <= pos_x_i; y_q <= pos_y_i; z_q <= pos_z_i;
      int_q <= intensity_i; ring_q <= ring_i;
    end
    rem_q <= rem_d; status_q <= status_d; col_q <= col_d; idx_q <= idx_d;
    if (st_q == SStart) begin
      rng_q <= '0;
    end else if (rdone) begin
      rng_q <= root;
    end
    if (st_q == SMul) begin
      prod_q <= ProdW'(ang - lrip_pkg::AngHalfPi) * ProdW'(COLUMN_COUNT);
    end
    // restoring divide of (2|p|+2pi) by 4pi, one quotient bit a cycle
    if (st_q == SMul) begin
      dn_q <= 6'(ProdW + 1);
      mag_q <= '0; k_q <= '0;
    end else if (st_q == SDiv && dn_q == 6'(ProdW + 1)) begin
      num_q <= ProdW'(((prod_q < 0) ? -prod_q : prod_q) <<< 1)
               + ProdW'(lrip_pkg::AngTwoPi);
      dn_q <= dn_q - 6'd1;
    end else if (st_q == SDiv && dn_q != '0) begin
      if ({mag_q[ProdW-2:0], num_q[ProdW-1]} >= ProdW'(den)) begin
        mag_q <= {mag_q[ProdW-2:0], num_q[ProdW-1]} - ProdW'(den);
        k_q <= {k_q[ProdW-2:0], 1'b1};
      end else begin
        mag_q <= {mag_q[ProdW-2:0], num_q[ProdW-1]};
        k_q <= {k_q[ProdW-2:0], 1'b0};
      end
      num_q <= num_q << 1;
      dn_q <= dn_q - 6'd1;
    end
    if (mwe) mem[maddr] <= mwd;
    taken_q <= mem[maddr];
  end

  assign status_o        = status_q;
  assign row_o           = (status_q == lrip_pkg::StRingOut || status_q == lrip_pkg::StSkipped)
                           ? '0 : ring_q[6:0];
  assign column_o        = col_q;
  assign cell_index_o    = idx_q;
  assign range_o         = (status_q == lrip_pkg::StRingOut || status_q == lrip_pkg::StSkipped)
                           ? '0 : rng_q;
  assign out_x_o         = x_q;
  assign out_y_o         = y_q;
  assign out_z_o         = z_q;
  assign out_intensity_o = int_q;

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, st_q != SIdle, in_stall_o)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_IMPL(a_status_ok, clk_i, rst_ni, out_valid_o, status_q <= lrip_pkg::StTaken)

endmodule
